// ----- design/partition_fit_allocator_defines.svh -----
// assertion macros shared by the partition fit allocator
`ifndef PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define PFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/pfa_pkg.sv -----
// types, codes and defaults of the partition fit allocator
`default_nettype none

package pfa_pkg;

   localparam int unsigned PARTITIONS_DEF = 8;
   localparam int unsigned SIZE_BITS_DEF  = 16;
   localparam int unsigned REQ_SIZE_W     = 16;
   localparam int unsigned INDEX_W        = 3;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_WORST = 2'd1,
      CMD_BEST  = 2'd2,
      CMD_FIRST = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_LOADED    = 2'd0,
      ST_ALLOCATED = 2'd1,
      ST_NOFIT     = 2'd2
   } status_type;

   typedef struct packed {
      command_type             command;
      logic [INDEX_W-1:0]      part_index;
      logic [REQ_SIZE_W-1:0]   request_size;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [INDEX_W-1:0]  granted_index;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic load_wr;
      logic capture;
      logic scan_rd;
      logic cnt_clr;
      logic cnt_inc;
      logic commit_wr;
      logic out_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cnt_last;
      logic req_load;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- design/pfa_channels.sv -----
// request and response channel interfaces
`default_nettype none

interface pfa_req_if;
   import pfa_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pfa_rsp_if;
   import pfa_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/pfa_ctrl.sv -----
// sequencing state machine of the partition fit allocator
`default_nettype none

module pfa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pfa_pkg::dp_stat_type  stat,
   output pfa_pkg::ctrl_cmd_type      cmd
);
   import pfa_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_LOAD   = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_SETTLE = 7'b0010000,
      S_COMMIT = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.cnt_inc  = 1'b1;
            if (stat.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.cnt_clr = 1'b1;
               state_in    = stat.req_load ? S_LOAD : S_SCAN;
            end
         end
         S_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_last) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit_wr = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/pfa_dp.sv -----
// partition table memory, scan compare and result register
`default_nettype none

module pfa_dp #(
   parameter int unsigned PARTITIONS = pfa_pkg::PARTITIONS_DEF,
   parameter int unsigned SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pfa_pkg::req_type       req_payload,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output pfa_pkg::rsp_type            rsp_payload,
   input  wire pfa_pkg::ctrl_cmd_type  cmd,
   output pfa_pkg::dp_stat_type        stat
);
   import pfa_pkg::*;

   localparam int unsigned IDX_W = $clog2(PARTITIONS);
   localparam int unsigned CMP_W = (SIZE_BITS > REQ_SIZE_W) ? SIZE_BITS : REQ_SIZE_W;
   localparam int unsigned PAD_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTITIONS - 1);

   // word layout: used flag on top, size below
   logic [SIZE_BITS:0]      part_mem_ff [PARTITIONS];
   logic [SIZE_BITS:0]      rd_word_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    rd_valid_ff;

   logic [IDX_W-1:0]        cnt_ff;
   logic [IDX_W-1:0]        cnt_in;

   command_type             op_cmd_ff;
   logic [INDEX_W-1:0]      op_index_ff;
   logic [REQ_SIZE_W-1:0]   op_size_ff;

   logic                    found_ff;
   logic                    found_in;
   logic [IDX_W-1:0]        pick_ff;
   logic [IDX_W-1:0]        pick_in;
   logic [SIZE_BITS-1:0]    pick_size_ff;
   logic [SIZE_BITS-1:0]    pick_size_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [SIZE_BITS:0]      wr_data;
   logic                    load_in_range;
   logic [SIZE_BITS-1:0]    load_size;
   logic [SIZE_BITS-1:0]    rd_size;
   logic                    rd_used;
   logic                    fits;
   logic                    take;
   logic [PAD_W-1:0]        pick_wide;

   assign stat.cnt_last = (cnt_ff == LAST_IDX);
   assign stat.req_load = (req_payload.command == CMD_LOAD);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // scan / clear address counter, wraps after the last partition
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = stat.cnt_last ? '0 : cnt_ff + 1'b1;
      end
   end

   // table write port
   assign load_in_range = (32'(op_index_ff) < PARTITIONS);
   assign load_size     = SIZE_BITS'(CMP_W'(op_size_ff));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = '0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (cmd.load_wr) begin
         wr_en   = load_in_range;
         wr_addr = IDX_W'(op_index_ff);
         wr_data = {1'b0, load_size};
      end else if (cmd.commit_wr) begin
         wr_en   = found_ff;
         wr_addr = pick_ff;
         wr_data = {1'b1, pick_size_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         part_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.scan_rd) begin
         rd_word_ff <= part_mem_ff[cnt_ff];
      end
      rd_idx_ff <= cnt_ff;
   end

   // fit test and selection
   assign rd_size = rd_word_ff[SIZE_BITS-1:0];
   assign rd_used = rd_word_ff[SIZE_BITS];
   assign fits    = !rd_used && (CMP_W'(rd_size) >= CMP_W'(op_size_ff));
   assign take    = rd_valid_ff && fits &&
                    (!found_ff ||
                     ((op_cmd_ff == CMD_WORST) && (rd_size > pick_size_ff)) ||
                     ((op_cmd_ff == CMD_BEST) && (rd_size < pick_size_ff)));

   always_comb begin
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_size_in = pick_size_ff;
      if (cmd.capture) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in     = 1'b1;
         pick_in      = rd_idx_ff;
         pick_size_in = rd_size;
      end
   end

   // result register
   assign pick_wide = PAD_W'(pick_ff);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         if (op_cmd_ff == CMD_LOAD) begin
            rsp_in.status        = ST_LOADED;
            rsp_in.granted_index = '0;
         end else if (found_ff) begin
            rsp_in.status        = ST_ALLOCATED;
            rsp_in.granted_index = pick_wide[INDEX_W-1:0];
         end else begin
            rsp_in.status        = ST_NOFIT;
            rsp_in.granted_index = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= cmd.scan_rd;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_cmd_ff   <= req_payload.command;
         op_index_ff <= req_payload.part_index;
         op_size_ff  <= req_payload.request_size;
      end
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- design/partition_fit_allocator.sv -----
// top level of the partition fit allocator: controller plus datapath
//
//   channel    dir   carries
//   req_chan   in    command, part_index, request_size
//   rsp_chan   out   status, granted_index
//
// after reset a clearing pass writes every partition to zero size, free,
// one entry a cycle, with req_chan.ready low
// a load request passes through the load and finish states before the next accept
// an allocation request reads the table through its single read port, one
// entry a cycle, then settles, commits and finishes before the next accept
// the response sits in an output register; a stalled rsp_chan holds it there,
// a new request is still taken and waits only at its own finish
`default_nettype none

`include "partition_fit_allocator_defines.svh"

module partition_fit_allocator #(
   parameter int unsigned PARTITIONS = pfa_pkg::PARTITIONS_DEF,
   parameter int unsigned SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pfa_req_if.sink    req_chan,
   pfa_rsp_if.source  rsp_chan
);
   import pfa_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_stat_type   dp_stat;
   logic [2:0]    wr_vec;

   // sequencer: clearing pass, load, scan, commit, result hand-off
   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   // partition table, fit compare, pick registers, response register
   pfa_dp #(
      .PARTITIONS (PARTITIONS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_chan.payload),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_payload (rsp_chan.payload),
      .cmd         (ctrl_cmd),
      .stat        (dp_stat)
   );

   // the three sources of the table write port never collide
   assign wr_vec = {ctrl_cmd.clear_wr, ctrl_cmd.load_wr, ctrl_cmd.commit_wr};

   // one request in flight: an accept drops ready on the next cycle
   `PFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "request accepted while previous one in flight")
   // the result register is only loaded when it is empty or being drained
   `PFA_ASSERT_NOW(a_no_overwrite, clock, reset, ctrl_cmd.out_load, !rsp_chan.valid || rsp_chan.ready, "response overwritten before it was taken")
   `PFA_ASSERT_NOW(a_single_writer, clock, reset, 1'b1, $onehot0(wr_vec), "table write port driven by two sources")
   // index is zero unless a partition was granted
   `PFA_ASSERT_NOW(a_index_zero, clock, reset, rsp_chan.valid && (rsp_chan.payload.status != ST_ALLOCATED), rsp_chan.payload.granted_index == '0, "granted index set without allocation")

endmodule

`default_nettype wire
